// ===== design/ptc_pkg.sv =====
// Package for the clamped-term PID controller: field widths, command and
// register index codes, request payload type. No dependencies.
`timescale 1ns / 1ps

package ptc_pkg;

   localparam int FieldWidth = 16;
   localparam int GainWidth  = 16;
   localparam int LimitWidth = 15;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 16;

   typedef enum logic [1:0] {
      CMD_SET_MEAS = 2'd0,
      CMD_ERROR    = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_RSVD     = 2'd3
   } cmd_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GAIN_PROP   = 3'd0,
      CSR_GAIN_INTEG  = 3'd1,
      CSR_GAIN_DERIV  = 3'd2,
      CSR_LIMIT_PROP  = 3'd3,
      CSR_LIMIT_INTEG = 3'd4,
      CSR_LIMIT_DERIV = 3'd5,
      CSR_LIMIT_TOTAL = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_idx_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [FieldWidth-1:0]  setpoint;
      logic signed [FieldWidth-1:0]  measured;
      logic signed [FieldWidth-1:0]  error_in;
   } req_type;

endpackage

// ===== design/ptc_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on ptc_pkg.
`timescale 1ns / 1ps

interface ptc_req_if;
   logic                                valid;
   logic                                ready;
   ptc_pkg::cmd_type                    cmd;
   logic signed [ptc_pkg::FieldWidth-1:0] setpoint;
   logic signed [ptc_pkg::FieldWidth-1:0] measured;
   logic signed [ptc_pkg::FieldWidth-1:0] error_in;

   modport source (output valid, cmd, setpoint, measured, error_in, input ready);
   modport sink   (input valid, cmd, setpoint, measured, error_in, output ready);
endinterface

interface ptc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ptc_pkg::FieldWidth-1:0] drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

// ===== design/pid_term_clamped_controller.sv =====
// Top level of the clamped-term PID controller: CSRs, input register,
// error/integral datapath and result register. Depends on ptc_pkg, ptc_if, ptc_term.
`timescale 1ns / 1ps

// Positional PID controller, fixed point. Each request transaction carries a
// command: setpoint and measurement, a direct error, or a history clear. One
// response transaction with the drive value follows every request, through the
// input register and then the result register; a new request is taken every
// cycle while the response side does not stall. The error, integral, three
// gain multiplies and clamps lie between those two registers. Gains
// are signed Q8.8 (GAIN_FRAC_BITS fraction bits), products are floored, each
// term is clamped to its own limit and the sum to limit_total. A clear command
// or the unused command returns zero; only the clear resets the history.
// CSRs are written with csr_we, csr_index and csr_wdata and should only be
// changed while no transaction is in flight.
module pid_term_clamped_controller #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8,
   parameter int INTEGRAL_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ptc_req_if.sink                              req_ch,
   ptc_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [ptc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [ptc_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import ptc_pkg::*;

   localparam int DiffWidth = FieldWidth + 1;
   localparam int ErrExtWidth = (DATA_WIDTH > DiffWidth) ? DATA_WIDTH : DiffWidth;
   localparam int SumWidth = ((INTEGRAL_WIDTH > DATA_WIDTH) ? INTEGRAL_WIDTH
                                                            : DATA_WIDTH) + 1;
   localparam int TotWidth = FieldWidth + 2;

   localparam logic signed [ErrExtWidth-1:0] ErrMax =
      $signed({{(ErrExtWidth-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [ErrExtWidth-1:0] ErrMin = ~ErrMax;
   localparam logic signed [SumWidth-1:0] IntMax =
      $signed({{(SumWidth-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}});
   localparam logic signed [SumWidth-1:0] IntMin = ~IntMax;

   // CSRs
   logic signed [GainWidth-1:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [LimitWidth-1:0]       limit_prop_ff, limit_integ_ff, limit_deriv_ff;
   logic [LimitWidth-1:0]       limit_total_ff;

   // pipeline
   req_type                     req_ff;
   logic                        req_valid_ff;
   logic                        rsp_valid_ff;
   logic signed [FieldWidth-1:0] drive_ff, drive_in;
   logic                        advance;

   // history
   logic signed [DATA_WIDTH-1:0]     prev_error_ff, prev_error_in;
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff, integral_in;

   // datapath
   logic signed [DiffWidth-1:0]      err_raw;
   logic signed [ErrExtWidth-1:0]    err_ext;
   logic signed [DATA_WIDTH-1:0]     err;
   logic signed [SumWidth-1:0]       int_sum;
   logic signed [INTEGRAL_WIDTH-1:0] int_sat;
   logic signed [DATA_WIDTH:0]       err_delta;
   logic signed [FieldWidth-1:0]     p_term, i_term, d_term;
   logic signed [TotWidth-1:0]       total;
   logic signed [TotWidth-1:0]       tot_pos, tot_neg;

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !req_valid_ff || advance;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.drive  = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= '0;
         gain_integ_ff  <= '0;
         gain_deriv_ff  <= '0;
         limit_prop_ff  <= '0;
         limit_integ_ff <= '0;
         limit_deriv_ff <= '0;
         limit_total_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_GAIN_PROP:   gain_prop_ff   <= $signed(csr_wdata[GainWidth-1:0]);
            CSR_GAIN_INTEG:  gain_integ_ff  <= $signed(csr_wdata[GainWidth-1:0]);
            CSR_GAIN_DERIV:  gain_deriv_ff  <= $signed(csr_wdata[GainWidth-1:0]);
            CSR_LIMIT_PROP:  limit_prop_ff  <= csr_wdata[LimitWidth-1:0];
            CSR_LIMIT_INTEG: limit_integ_ff <= csr_wdata[LimitWidth-1:0];
            CSR_LIMIT_DERIV: limit_deriv_ff <= csr_wdata[LimitWidth-1:0];
            CSR_LIMIT_TOTAL: limit_total_ff <= csr_wdata[LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_ff.cmd == CMD_SET_MEAS) begin
         err_raw = DiffWidth'(req_ff.setpoint) - DiffWidth'(req_ff.measured);
      end else begin
         err_raw = DiffWidth'(req_ff.error_in);
      end
      err_ext = ErrExtWidth'(err_raw);
      if (err_ext > ErrMax) begin
         err = ErrMax[DATA_WIDTH-1:0];
      end else if (err_ext < ErrMin) begin
         err = ErrMin[DATA_WIDTH-1:0];
      end else begin
         err = err_ext[DATA_WIDTH-1:0];
      end

      int_sum = SumWidth'(integral_ff) + SumWidth'(err);
      if (int_sum > IntMax) begin
         int_sat = IntMax[INTEGRAL_WIDTH-1:0];
      end else if (int_sum < IntMin) begin
         int_sat = IntMin[INTEGRAL_WIDTH-1:0];
      end else begin
         int_sat = int_sum[INTEGRAL_WIDTH-1:0];
      end

      err_delta = (DATA_WIDTH+1)'(err) - (DATA_WIDTH+1)'(prev_error_ff);
   end

   ptc_term #(.OPND_WIDTH(DATA_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_prop (
      .gain(gain_prop_ff), .operand(err), .limit(limit_prop_ff), .term(p_term)
   );
   ptc_term #(.OPND_WIDTH(INTEGRAL_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_integ (
      .gain(gain_integ_ff), .operand(int_sat), .limit(limit_integ_ff), .term(i_term)
   );
   ptc_term #(.OPND_WIDTH(DATA_WIDTH+1), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_deriv (
      .gain(gain_deriv_ff), .operand(err_delta), .limit(limit_deriv_ff), .term(d_term)
   );

   always_comb begin
      total   = TotWidth'(p_term) + TotWidth'(i_term) + TotWidth'(d_term);
      tot_pos = $signed({{(TotWidth-LimitWidth){1'b0}}, limit_total_ff});
      tot_neg = -tot_pos;
      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      drive_in      = '0;
      case (req_ff.cmd) inside
         CMD_SET_MEAS, CMD_ERROR: begin
            prev_error_in = err;
            integral_in   = int_sat;
            if (total > tot_pos) begin
               drive_in = tot_pos[FieldWidth-1:0];
            end else if (total < tot_neg) begin
               drive_in = tot_neg[FieldWidth-1:0];
            end else begin
               drive_in = total[FieldWidth-1:0];
            end
         end
         CMD_CLEAR: begin
            prev_error_in = '0;
            integral_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            prev_error_ff <= prev_error_in;
            integral_ff   <= integral_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_ff.cmd      <= req_ch.cmd;
         req_ff.setpoint <= req_ch.setpoint;
         req_ff.measured <= req_ch.measured;
         req_ff.error_in <= req_ch.error_in;
      end
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

endmodule

// ===== design/ptc_term.sv =====
// One controller term: gain times operand, floor scaling, symmetric clamp.
// Depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_term #(
   parameter int OPND_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic signed [ptc_pkg::GainWidth-1:0]  gain,
   input  logic signed [OPND_WIDTH-1:0]          operand,
   input  logic        [ptc_pkg::LimitWidth-1:0] limit,
   output logic signed [ptc_pkg::FieldWidth-1:0] term
);
   import ptc_pkg::*;

   localparam int ProdWidth = GainWidth + OPND_WIDTH;

   logic signed [ProdWidth-1:0] prod;
   logic signed [ProdWidth-1:0] scaled;
   logic signed [ProdWidth-1:0] lim_pos;
   logic signed [ProdWidth-1:0] lim_neg;

   always_comb begin
      prod    = ProdWidth'(gain) * ProdWidth'(operand);
      // arithmetic shift gives floor for negative products
      scaled  = prod >>> GAIN_FRAC_BITS;
      lim_pos = $signed({{(ProdWidth-LimitWidth){1'b0}}, limit});
      lim_neg = -lim_pos;
      if (scaled > lim_pos) begin
         term = lim_pos[FieldWidth-1:0];
      end else if (scaled < lim_neg) begin
         term = lim_neg[FieldWidth-1:0];
      end else begin
         term = scaled[FieldWidth-1:0];
      end
   end

endmodule

// ===== design/ptc_checker.sv =====
// Port-level assertions for the clamped-term PID controller, bound to the top.
// Depends on ptc_pkg and pid_term_clamped_controller.
`timescale 1ns / 1ps

module ptc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [ptc_pkg::FieldWidth-1:0] rsp_drive
);
   import ptc_pkg::*;

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // empty output stage never back-pressures the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // a new response comes from an accepted request, via the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request");

endmodule

bind pid_term_clamped_controller ptc_checker u_ptc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_drive(rsp_ch.drive)
);
